@@ rtl/core/cnfp_pkg.sv @@
// ----------------------------------------------------------------------------
// cnfp_pkg
// Shared constants, types and helpers for the common-neighbour friend picker.
// ----------------------------------------------------------------------------
package cnfp_pkg;

   localparam int MAX_USERS  = 64;
   localparam int MAX_GRAPHS = 4;

   // field widths fixed by the interface
   localparam int MASK_W   = 64;
   localparam int STATUS_W = 2;
   localparam int ID_W     = 6;
   localparam int GIDX_W   = 2;

   localparam int USER_W     = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int GRAPH_W    = (MAX_GRAPHS > 1) ? $clog2(MAX_GRAPHS) : 1;
   localparam int ROWS       = MAX_GRAPHS * MAX_USERS;
   localparam int ROW_ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W      = $clog2(MASK_W + 1);

   localparam logic [MASK_W-1:0] USER_MASK = {MASK_W{1'b1}} >> (MASK_W - MAX_USERS);

   typedef enum logic [STATUS_W-1:0] {
      ST_WRITE_DONE = 2'd0,
      ST_FOUND      = 2'd1,
      ST_NOT_FOUND  = 2'd2,
      ST_NONE       = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROW,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   // control from the sequencer to the candidate scan unit
   typedef struct packed {
      logic              clear;
      logic              eval;
      logic [USER_W-1:0] id;
   } scan_ctrl_type;

   typedef struct packed {
      logic              have;
      logic [USER_W-1:0] best_id;
   } scan_result_type;

   function automatic logic [CNT_W-1:0] pop_count(input logic [MASK_W-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < MASK_W; i++) begin
         n = n + CNT_W'(v[i]);
      end
      return n;
   endfunction

   function automatic logic [ROW_ADDR_W-1:0] row_addr(input logic [GRAPH_W-1:0] graph,
                                                     input logic [USER_W-1:0] user);
      return ROW_ADDR_W'(graph) * ROW_ADDR_W'(MAX_USERS) + ROW_ADDR_W'(user);
   endfunction

endpackage

@@ rtl/core/common_neighbor_friend_pick.sv @@
// ----------------------------------------------------------------------------
// common_neighbor_friend_pick
// Common-neighbour friend recommender over several stored graphs.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A row write, or a query
// of an absent user, is answered on the cycle after it is taken and the block
// can take the next word at once. A query of a present user runs through the
// states S_ROW, S_SCAN, S_DRAIN and S_DONE: S_ROW has the user's row out of
// the memory and its count checked, S_SCAN makes one row-memory read per
// candidate id (all 64 ids walked through the single read port), S_DRAIN
// scores the last row, S_DONE forms the answer, and the answer is then shown
// from a register. When the row holds one user fewer than the graph has
// present users, S_ROW forms the answer itself and the scan is skipped. busy
// falls while the answer is shown, so the next word can be taken at the edge
// that takes the answer. The answer is shown for one cycle with rsp_valid; it
// cannot be held off, so the receiver must take it then.
module common_neighbor_friend_pick (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_mode,
   input  logic [cnfp_pkg::GIDX_W-1:0]       req_graph_index,
   input  logic [cnfp_pkg::ID_W-1:0]         req_user_id,
   input  logic [cnfp_pkg::MASK_W-1:0]       req_neighbor_mask,
   output logic                              rsp_valid,
   output logic [cnfp_pkg::STATUS_W-1:0]     rsp_status,
   output logic [cnfp_pkg::ID_W-1:0]         rsp_pick_id
);
   import cnfp_pkg::*;

   state_type          state_ff, state_in;
   logic [MASK_W-1:0]  present_ff [MAX_GRAPHS];
   logic [GRAPH_W-1:0] q_graph_ff;
   logic [USER_W-1:0]  q_user_ff;
   logic [MASK_W-1:0]  row_ff;
   logic [MAX_USERS-1:0] cands_ff;
   logic [USER_W-1:0]  cnt_ff;
   logic               tag_valid_ff;
   logic [USER_W-1:0]  tag_id_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;

   logic                  accept;
   logic [GRAPH_W-1:0]    req_g;
   logic [USER_W-1:0]     req_u;
   logic                  req_ok;
   logic                  req_present;
   logic                  ram_we;
   logic [ROW_ADDR_W-1:0] ram_waddr;
   logic [ROW_ADDR_W-1:0] ram_raddr;
   logic [MASK_W-1:0]     ram_rdata;
   logic [MASK_W-1:0]     pres_q;
   logic [MASK_W-1:0]     cands;
   logic                  row_full;
   logic                  scan_last;
   scan_ctrl_type         scan_ctrl;
   scan_result_type       scan_res;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign req_g  = req_graph_index[GRAPH_W-1:0];
   assign req_u  = req_user_id[USER_W-1:0];
   assign req_ok = (32'(req_graph_index) < MAX_GRAPHS) && (32'(req_user_id) < MAX_USERS);
   assign req_present = present_ff[req_g][req_u];
   assign ram_waddr   = row_addr(req_g, req_u);

   assign pres_q    = present_ff[q_graph_ff];
   assign cands     = pres_q & ~ram_rdata & ~(MASK_W'(1) << q_user_ff);
   assign row_full  = (pop_count(ram_rdata) + CNT_W'(1)) == pop_count(pres_q);
   assign scan_last = (cnt_ff == USER_W'(MAX_USERS - 1));

   // a read in the same cycle as a write to that row returns the old row
   cnfp_row_ram #(
      .WIDTH  (MASK_W),
      .DEPTH  (ROWS),
      .ADDR_W (ROW_ADDR_W)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_neighbor_mask & USER_MASK),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign scan_ctrl.clear = (state_ff == S_ROW);
   assign scan_ctrl.eval  = tag_valid_ff;
   assign scan_ctrl.id    = tag_id_ff;

   cnfp_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (scan_ctrl),
      .user_row (row_ff),
      .cand_row (ram_rdata),
      .result   (scan_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_mode && req_ok && req_present) begin
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            state_in = row_full ? S_IDLE : S_SCAN;
         end
         S_SCAN: begin
            if (scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ram_we        = 1'b0;
      ram_raddr     = row_addr(q_graph_ff, cnt_ff);
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_WRITE_DONE;
      rsp_id_in     = '0;
      case (state_ff)
         S_IDLE: begin
            ram_raddr = row_addr(req_g, req_u);
            if (accept) begin
               if (!req_mode) begin
                  ram_we       = req_ok;
                  rsp_valid_in = 1'b1;
               end else if (!(req_ok && req_present)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOT_FOUND;
               end
            end
         end
         S_ROW: begin
            if (row_full) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NONE;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            if (scan_res.have) begin
               rsp_status_in = ST_FOUND;
               rsp_id_in     = ID_W'(scan_res.best_id);
            end else begin
               rsp_status_in = ST_NONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         tag_valid_ff <= 1'b0;
         for (int g = 0; g < MAX_GRAPHS; g++) begin
            present_ff[g] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tag_valid_ff <= (state_ff == S_SCAN) && cands_ff[cnt_ff];
         if (ram_we) begin
            present_ff[req_g][req_u] <= 1'b1;
         end
      end
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      tag_id_ff     <= cnt_ff;
      if (accept) begin
         q_graph_ff <= req_g;
         q_user_ff  <= req_u;
      end
      if (state_ff == S_ROW) begin
         row_ff   <= ram_rdata;
         cands_ff <= cands[MAX_USERS-1:0];
         cnt_ff   <= '0;
      end else if (state_ff == S_SCAN) begin
         cnt_ff <= cnt_ff + USER_W'(1);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_pick_id = rsp_id_ff;

   a_done_answers : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_valid)
      else $error("query finished without an answer");

   a_friend_present : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FOUND |-> present_ff[q_graph_ff][rsp_pick_id[USER_W-1:0]])
      else $error("recommended user is not present");

   a_friend_not_self : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FOUND |-> rsp_pick_id[USER_W-1:0] != q_user_ff)
      else $error("user recommended to itself");

   a_id_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FOUND |-> rsp_pick_id == '0)
      else $error("friend id set without a find");

endmodule

@@ rtl/core/cnfp_row_ram.sv @@
// ----------------------------------------------------------------------------
// cnfp_row_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cnfp_row_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/cnfp_scan.sv @@
// ----------------------------------------------------------------------------
// cnfp_scan
// Candidate scorer: shared-neighbour count and degree, keeps the best so far.
// ----------------------------------------------------------------------------
module cnfp_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  cnfp_pkg::scan_ctrl_type         ctrl,
   input  logic [cnfp_pkg::MASK_W-1:0]     user_row,
   input  logic [cnfp_pkg::MASK_W-1:0]     cand_row,
   output cnfp_pkg::scan_result_type       result
);
   import cnfp_pkg::*;

   logic [CNT_W-1:0]  share;
   logic [CNT_W-1:0]  degree;
   logic [CNT_W-1:0]  best_share_ff, best_share_in;
   logic [CNT_W-1:0]  best_deg_ff, best_deg_in;
   logic [USER_W-1:0] best_id_ff, best_id_in;
   logic              have_ff, have_in;

   assign share  = pop_count(cand_row & user_row);
   assign degree = pop_count(cand_row);

   always_comb begin
      best_share_in = best_share_ff;
      best_deg_in   = best_deg_ff;
      best_id_in    = best_id_ff;
      have_in       = have_ff;
      if (ctrl.clear) begin
         best_share_in = '0;
         best_deg_in   = '0;
         best_id_in    = '0;
         have_in       = 1'b0;
      end else if (ctrl.eval) begin
         if (share > best_share_ff) begin
            best_share_in = share;
            best_id_in    = ctrl.id;
            have_in       = 1'b1;
         end else if (share == '0 && best_share_ff == '0) begin
            // nobody shares anything yet: fall back to the highest degree
            if (!have_ff || degree > best_deg_ff) begin
               best_deg_in = degree;
               best_id_in  = ctrl.id;
               have_in     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      best_share_ff <= best_share_in;
      best_deg_ff   <= best_deg_in;
      best_id_ff    <= best_id_in;
   end

   assign result.have    = have_ff;
   assign result.best_id = best_id_ff;

endmodule
